[rtl/core/bam_pkg.sv]
package bam_pkg;

	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;

	localparam logic [3:0] MIN_CELL = 4'd4;
	localparam logic [3:0] MAX_CELL = 4'd14;

	localparam logic [1:0] REG_CELL_SIZE = 2'd0;
	localparam logic [1:0] REG_WIDTH     = 2'd1;
	localparam logic [1:0] REG_HEIGHT    = 2'd2;

	localparam int DIV_STEPS = 8;

	typedef struct packed {
		logic accept;
		logic acc;
		logic div_step;
		logic load_out;
		logic clear_step;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic clear_done;
		logic out_free;
	} status_t;

endpackage

[rtl/core/bam_ctrl.sv]
module bam_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            cfg_we,
	input  bam_pkg::status_t st,
	output logic            in_ready,
	output bam_pkg::cmd_t   cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_ACC   = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam int SCW = $clog2(bam_pkg::DIV_STEPS);

	logic [2:0]     state_q, state_d;
	logic [SCW-1:0] step_q, step_d;

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (st.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				step_d  = '0;
				state_d = st.last ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				step_d = step_q + 1'b1;
				if (step_q == SCW'(bam_pkg::DIV_STEPS - 1)) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
		if (cfg_we) state_d = ST_CLEAR;
	end

	assign in_ready = (state_q == ST_IDLE) && !cfg_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

endmodule

[rtl/core/bam_dpath.sv]
module bam_dpath #(
	parameter int MAX_WIDTH  = bam_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bam_pkg::DEF_MAX_HEIGHT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bam_pkg::cmd_t    cmd,
	output bam_pkg::status_t st,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [11:0]      cfg_data,
	input  logic [7:0]       pix_red,
	input  logic [7:0]       pix_green,
	input  logic [7:0]       pix_blue,
	input  logic [7:0]       pix_alpha,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [8:0]       cell_column,
	output logic [8:0]       cell_row,
	output logic [7:0]       avg_red,
	output logic [7:0]       avg_green,
	output logic [7:0]       avg_blue,
	output logic [7:0]       avg_alpha,
	output logic             frame_done
);

	localparam int CELL_COLS = (MAX_WIDTH + 3) / 4;
	localparam int CELL_ROWS = (MAX_HEIGHT + 3) / 4;
	localparam int CCW = $clog2(CELL_COLS);
	localparam int CRW = $clog2(CELL_ROWS);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int MW  = 72;

	logic [3:0]    cs_q;
	logic [WW-1:0] rw_q, col_pos_q;
	logic [HW-1:0] rh_q, row_pos_q;
	logic [3:0]    off_x_q, off_y_q;
	logic [CCW-1:0] cell_col_q, addr_q, clr_q;
	logic [CRW-1:0] cell_row_q, row_idx_q;
	logic           last_q, frame_q;
	logic [7:0]     pr_q, pg_q, pb_q, pa_q;

	logic [MW-1:0] mem [CELL_COLS];
	logic [MW-1:0] rd_q;

	logic [7:0]  div_q;
	logic [7:0]  rem_q [4];
	logic [7:0]  low_q [4];

	logic [4:0]  cs_ext;
	logic        end_x, end_y, wrap_x, wrap_y;
	logic [15:0] sum_n [4];
	logic [7:0]  cnt_n;

	assign cs_ext = {1'b0, cs_q};
	assign wrap_x = ({1'b0, off_x_q} + 5'd1) >= cs_ext;
	assign wrap_y = ({1'b0, off_y_q} + 5'd1) >= cs_ext;
	assign end_x  = ({1'b0, col_pos_q} + (WW+1)'(1)) >= {1'b0, rw_q};
	assign end_y  = ({1'b0, row_pos_q} + (HW+1)'(1)) >= {1'b0, rh_q};

	assign sum_n[0] = rd_q[71:56] + {8'd0, pr_q};
	assign sum_n[1] = rd_q[55:40] + {8'd0, pg_q};
	assign sum_n[2] = rd_q[39:24] + {8'd0, pb_q};
	assign sum_n[3] = rd_q[23:8]  + {8'd0, pa_q};
	assign cnt_n    = rd_q[7:0] + 8'd1;

	assign st.last       = last_q;
	assign st.clear_done = (clr_q == CCW'(CELL_COLS - 1));
	assign st.out_free   = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q <= bam_pkg::MIN_CELL;
			rw_q <= WW'(MAX_WIDTH);
			rh_q <= HW'(MAX_HEIGHT);
		end else if (cfg_we) begin
			case (cfg_index)
				bam_pkg::REG_CELL_SIZE: begin
					if (cfg_data[3:0] < bam_pkg::MIN_CELL) cs_q <= bam_pkg::MIN_CELL;
					else if (cfg_data[3:0] > bam_pkg::MAX_CELL) cs_q <= bam_pkg::MAX_CELL;
					else cs_q <= cfg_data[3:0];
				end
				bam_pkg::REG_WIDTH: begin
					if (cfg_data == 12'd0) rw_q <= WW'(1);
					else if (32'(cfg_data) > 32'(MAX_WIDTH)) rw_q <= WW'(MAX_WIDTH);
					else rw_q <= WW'(cfg_data);
				end
				bam_pkg::REG_HEIGHT: begin
					if (cfg_data == 12'd0) rh_q <= HW'(1);
					else if (32'(cfg_data) > 32'(MAX_HEIGHT)) rh_q <= HW'(MAX_HEIGHT);
					else rh_q <= HW'(cfg_data);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q  <= '0;
			row_pos_q  <= '0;
			off_x_q    <= '0;
			off_y_q    <= '0;
			cell_col_q <= '0;
			cell_row_q <= '0;
			clr_q      <= '0;
		end else if (cfg_we) begin
			col_pos_q  <= '0;
			row_pos_q  <= '0;
			off_x_q    <= '0;
			off_y_q    <= '0;
			cell_col_q <= '0;
			cell_row_q <= '0;
			clr_q      <= '0;
		end else begin
			if (cmd.clear_step && !st.clear_done) clr_q <= clr_q + 1'b1;
			if (cmd.accept) begin
				if (end_x) begin
					col_pos_q  <= '0;
					off_x_q    <= '0;
					cell_col_q <= '0;
					if (end_y) begin
						row_pos_q  <= '0;
						off_y_q    <= '0;
						cell_row_q <= '0;
					end else begin
						row_pos_q <= row_pos_q + 1'b1;
						if (wrap_y) begin
							off_y_q    <= '0;
							cell_row_q <= cell_row_q + 1'b1;
						end else begin
							off_y_q <= off_y_q + 1'b1;
						end
					end
				end else begin
					col_pos_q <= col_pos_q + 1'b1;
					if (wrap_x) begin
						off_x_q    <= '0;
						cell_col_q <= cell_col_q + 1'b1;
					end else begin
						off_x_q <= off_x_q + 1'b1;
					end
				end
			end
		end
	end

	// pixel capture and registered memory read
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pr_q      <= pix_red;
			pg_q      <= pix_green;
			pb_q      <= pix_blue;
			pa_q      <= pix_alpha;
			addr_q    <= cell_col_q;
			row_idx_q <= cell_row_q;
			last_q    <= (wrap_x || end_x) && (wrap_y || end_y);
			frame_q   <= end_x && end_y;
			rd_q      <= mem[cell_col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			mem[clr_q] <= '0;
		end else if (cmd.acc) begin
			if (last_q) mem[addr_q] <= '0;
			else mem[addr_q] <= {sum_n[0], sum_n[1], sum_n[2], sum_n[3], cnt_n};
		end
	end

	// restoring divide, four channels in parallel, one quotient bit per step
	always_ff @(posedge clk) begin
		logic [8:0] t;
		if (cmd.acc) begin
			div_q <= cnt_n;
			for (int i = 0; i < 4; i++) begin
				rem_q[i] <= sum_n[i][15:8];
				low_q[i] <= sum_n[i][7:0];
			end
		end else if (cmd.div_step) begin
			for (int i = 0; i < 4; i++) begin
				t = {rem_q[i], low_q[i][7]};
				if (t >= {1'b0, div_q}) begin
					rem_q[i] <= 8'(t - {1'b0, div_q});
					low_q[i] <= {low_q[i][6:0], 1'b1};
				end else begin
					rem_q[i] <= t[7:0];
					low_q[i] <= {low_q[i][6:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.load_out) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			cell_column <= 9'(addr_q);
			cell_row    <= 9'(row_idx_q);
			avg_red     <= low_q[0];
			avg_green   <= low_q[1];
			avg_blue    <= low_q[2];
			avg_alpha   <= low_q[3];
			frame_done  <= frame_q;
		end
	end

endmodule

[rtl/core/block_average_mosaic_core.sv]
// Each pixel gets a registered read of its column accumulator and is then added in
// (memory RMW); a pixel that closes a cell also runs the divider and a registered
// output load, which waits while the output is stalled. No new pixel is accepted
// until the last one is through. Reset and every config write start a clear sweep over
// the (MAX_WIDTH+3)/4 column accumulators; no pixels are accepted during the sweep.
module block_average_mosaic_core #(
	parameter int MAX_WIDTH  = bam_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bam_pkg::DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  pix_red,
	input  logic [7:0]  pix_green,
	input  logic [7:0]  pix_blue,
	input  logic [7:0]  pix_alpha,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [8:0]  cell_column,
	output logic [8:0]  cell_row,
	output logic [7:0]  avg_red,
	output logic [7:0]  avg_green,
	output logic [7:0]  avg_blue,
	output logic [7:0]  avg_alpha,
	output logic        frame_done
);

	bam_pkg::cmd_t    cmd;
	bam_pkg::status_t st;

	bam_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cfg_we   (cfg_we),
		.st       (st),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	bam_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pix_red     (pix_red),
		.pix_green   (pix_green),
		.pix_blue    (pix_blue),
		.pix_alpha   (pix_alpha),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cell_column (cell_column),
		.cell_row    (cell_row),
		.avg_red     (avg_red),
		.avg_green   (avg_green),
		.avg_blue    (avg_blue),
		.avg_alpha   (avg_alpha),
		.frame_done  (frame_done)
	);

`ifndef SYNTHESIS
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready) else $error("request accepted during clear sweep");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("back-to-back request taken");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> st.out_free) else $error("result overwritten");
`endif

endmodule
